// ===== src/lsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// LED start-bit stream packer: shared package
// Beat types, the queue entry between front and back, and frame constants.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  // Largest LED count per frame that the block honors.
  localparam int unsigned MaxLeds = 4096;
  // Width of the LED count register.
  localparam int unsigned CountW  = 13;
  // Bits each LED adds: one start bit and three color bytes.
  localparam int unsigned LedBits = 25;

  // Input beat: one LED color.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  // Output beat: one byte of the serialized frame.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       item_done;
    logic       frame_done;
  } out_beat_t;

  // Work for one item, handed from front to back.
  typedef struct packed {
    logic [31:0] aligned;     // data bits left-aligned, zero padded below
    logic [2:0]  zero_bytes;  // leading zero header bytes (0, 6 or 7)
    logic [2:0]  data_bytes;  // bytes taken from aligned (3 or 4)
    logic        last;        // item closes the frame
  } entry_t;

endpackage

// ===== src/lsbp_front.sv =====
// ----------------------------------------------------------------------------
// LED start-bit stream packer: front end
// Accepts color beats, tracks frame position and leftover bits, and builds
// one queue entry per item describing the bytes it produces.
// ----------------------------------------------------------------------------
module lsbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            frame_len_we_i,
  input  logic [lsbp_pkg::CountW-1:0]     frame_len_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lsbp_pkg::in_beat_t              in_data_i,
  output logic                            push_o,
  output lsbp_pkg::entry_t                entry_o,
  input  logic                            full_i
);

  logic [lsbp_pkg::CountW-1:0] frame_len_q;
  logic [lsbp_pkg::CountW-1:0] leds_done_q, leds_done_d;
  logic [6:0]                  pend_bits_q, pend_bits_d;
  logic [2:0]                  pend_cnt_q, pend_cnt_d;

  logic [lsbp_pkg::CountW-1:0] eff;
  logic [lsbp_pkg::CountW:0]   done_inc;
  logic                        start;
  logic                        last;
  logic [2:0]                  lead;
  logic [2:0]                  c;
  logic [2:0]                  r;
  logic [6:0]                  p;
  logic [31:0]                 word;
  logic                        flush;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the item: header, packed word and frame end.
  always_comb begin
    if (frame_len_q == '0) begin
      eff = lsbp_pkg::CountW'(1);
    end else if (frame_len_q > lsbp_pkg::CountW'(lsbp_pkg::MaxLeds)) begin
      eff = lsbp_pkg::CountW'(lsbp_pkg::MaxLeds);
    end else begin
      eff = frame_len_q;
    end
    start    = (leds_done_q == '0);
    done_inc = {1'b0, leds_done_q} + {{lsbp_pkg::CountW{1'b0}}, 1'b1};
    last     = (done_inc >= {1'b0, eff});
    // Header length is 50 plus the padding that ends the frame on a byte;
    // its odd bits sit in front of the first LED like leftover bits.
    lead = 3'd6 - eff[2:0];
    c    = start ? (lead + 3'd2) : pend_cnt_q;
    p    = start ? 7'd0 : (pend_bits_q & ~(7'h7F << c));
    word = ({25'd0, p} << lsbp_pkg::LedBits) |
           {7'd0, 1'b1, in_data_i.blue, in_data_i.red, in_data_i.green};
    r     = c + 3'd1;
    flush = last && (r != 3'd0);

    entry_o.aligned    = word << (3'd7 - c);
    entry_o.zero_bytes = start ? ((lead >= 3'd6) ? 3'd7 : 3'd6) : 3'd0;
    entry_o.data_bytes = 3'd3 + {2'd0, (c == 3'd7)} + {2'd0, flush};
    entry_o.last       = last;

    leds_done_d = last ? '0 : done_inc[lsbp_pkg::CountW-1:0];
    pend_bits_d = last ? 7'd0 : (word[6:0] & ~(7'h7F << r));
    pend_cnt_d  = last ? 3'd0 : r;
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= lsbp_pkg::CountW'(1);
    end else if (frame_len_we_i) begin
      frame_len_q <= frame_len_i;
    end
  end

  // Frame position and leftover bits advance on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_done_q <= '0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (push_o) begin
      leds_done_q <= leds_done_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

// ===== src/lsbp_fifo.sv =====
// ----------------------------------------------------------------------------
// LED start-bit stream packer: work queue
// Two-entry queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module lsbp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsbp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lsbp_pkg::entry_t head_o
);

  lsbp_pkg::entry_t slots_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slots_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== src/lsbp_back.sv =====
// ----------------------------------------------------------------------------
// LED start-bit stream packer: back end
// Walks the head entry into the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module lsbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  lsbp_pkg::entry_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsbp_pkg::out_beat_t out_data_o
);

  logic [3:0]          step_q, step_d;
  logic                out_valid_q;
  lsbp_pkg::out_beat_t out_q;
  lsbp_pkg::out_beat_t beat;
  logic                advance;
  logic [3:0]          total;
  logic [1:0]          rel;
  logic [7:0]          data_byte;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign advance     = !empty_i && (!out_valid_q || out_ready_i);

  // Pick the byte at the current step of the head entry.
  always_comb begin
    total = {1'b0, head_i.zero_bytes} + {1'b0, head_i.data_bytes};
    rel   = step_q[1:0] - head_i.zero_bytes[1:0];
    unique case (rel)
      2'd0:    data_byte = head_i.aligned[31:24];
      2'd1:    data_byte = head_i.aligned[23:16];
      2'd2:    data_byte = head_i.aligned[15:8];
      default: data_byte = head_i.aligned[7:0];
    endcase
    beat.stream_byte = (step_q < {1'b0, head_i.zero_bytes}) ? 8'd0 : data_byte;
    beat.item_done   = (step_q == total - 4'd1);
    beat.frame_done  = beat.item_done && head_i.last;
    pop_o            = advance && beat.item_done;
    step_d           = beat.item_done ? 4'd0 : step_q + 4'd1;
  end

  // Step counter within the head entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 4'd0;
    end else if (advance) begin
      step_q <= step_d;
    end
  end

  // Output register: holds a beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= beat;
    end
  end

endmodule

// ===== src/led_start_bit_stream_packer_top.sv =====
// ----------------------------------------------------------------------------
// LED start-bit stream packer: top level
// Packs LED colors into an MSB-first byte stream with a zero header per frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one LED color per beat (red, green, blue). The
// output channel gives one stream byte per beat, flagged with item_done on
// the last byte an item causes and frame_done on the last byte of a frame.
// Each LED adds a start bit and 24 data bits sent blue, red, green; a frame
// opens with 50 to 57 zero bits so it ends on a byte boundary.
// The user writes the frame length through frame_len_we_i only while the
// block is idle; the block itself does not enforce this. The first byte
// of an item passes through the queue, then the output register. Output is
// one byte per cycle while the receiver keeps up, set by the serializer in
// the back end: 3 to 4 bytes per LED, 9 to 10 for the first of a frame.
// A two-entry queue sits between the front end and the serializer, so input
// beats keep being accepted while output bytes wait; when the receiver
// stalls, the output register holds its byte and the queue fills, after
// which in_ready_o drops.
// Reset empties the queue, starts a new frame and sets the frame length to one.
// ----------------------------------------------------------------------------
module led_start_bit_stream_packer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        frame_len_we_i,
  input  logic [lsbp_pkg::CountW-1:0] frame_len_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lsbp_pkg::in_beat_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lsbp_pkg::out_beat_t         out_data_o
);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  lsbp_pkg::entry_t entry;
  lsbp_pkg::entry_t head;

  // Front end: classification and frame state.
  lsbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_len_we_i (frame_len_we_i),
    .frame_len_i    (frame_len_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .push_o         (push),
    .entry_o        (entry),
    .full_i         (full)
  );

  // Work queue between the two halves.
  lsbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back end: byte serializer.
  lsbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/led_start_bit_stream_packer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED start-bit stream packer: self-checking testbench
// Drives LED colors into the packer and checks every output byte, with its
// item_done and frame_done flags, against a bit-level predictor kept here.
// A short directed table covers the reset count, color extremes, zero and
// over-limit LED counts and a count change in mid-frame. Random bursts then
// follow under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module led_start_bit_stream_packer_top_tb;

  // Idle cycles before a count write and at the end.
  localparam int unsigned SettleCycles = 8;
  // Longest run of cycles without any beat before the run is abandoned.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HeaderBits   = 50;
  localparam int unsigned LedsPerPhase = 40;

  typedef enum logic {RowWrite, RowLed} row_kind_e;

  // One row of the directed table: a count write or one LED color. Rows with
  // a typed-in stream are single-LED frames whose ten bytes are fixed.
  typedef struct packed {
    row_kind_e                   kind;
    logic [lsbp_pkg::CountW-1:0] count;
    lsbp_pkg::in_beat_t          led;
    logic                        typed;
    logic [79:0]                 stream;
  } stim_row_t;

  localparam int unsigned NumRows = 26;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // Reset count of one: 55 header zeros, start bit, blue, red, green.
    '{RowLed,   13'd0,    {8'h00, 8'h00, 8'h00}, 1'b1, 80'h000000000000_01_000000},
    '{RowLed,   13'd0,    {8'hFF, 8'hFF, 8'hFF}, 1'b1, 80'h000000000000_01_FFFFFF},
    '{RowLed,   13'd0,    {8'hA5, 8'h5A, 8'h3C}, 1'b1, 80'h000000000000_01_3CA55A},
    // A count of zero behaves as one.
    '{RowWrite, 13'd0,    24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h01, 8'h80, 8'h7E}, 1'b1, 80'h000000000000_01_7E0180},
    '{RowWrite, 13'd2,    24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h12, 8'h34, 8'h56}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'hFF, 8'h00, 8'hFF}, 1'b0, 80'h0},
    '{RowWrite, 13'd3,    24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h00, 8'hFF, 8'h00}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h80, 8'h01, 8'hC3}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h55, 8'hAA, 8'h0F}, 1'b0, 80'h0},
    // Largest register value is clamped; then the count drops below the
    // LEDs already sent, so the next LED closes the frame with a padded byte.
    '{RowWrite, 13'h1FFF, 24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h0F, 8'hF0, 8'h81}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'hC0, 8'h03, 8'h99}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h7F, 8'hFE, 8'h01}, 1'b0, 80'h0},
    '{RowWrite, 13'd2,    24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'hE7, 8'h18, 8'h66}, 1'b0, 80'h0},
    // Exactly at the limit, then one above it, then back to one.
    '{RowWrite, 13'd4096, 24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h11, 8'h22, 8'h33}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'hEE, 8'hDD, 8'hCC}, 1'b0, 80'h0},
    '{RowWrite, 13'd4097, 24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h44, 8'h88, 8'hBB}, 1'b0, 80'h0},
    '{RowWrite, 13'd1,    24'h0,                 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'h9A, 8'hBC, 8'hDE}, 1'b0, 80'h0},
    '{RowLed,   13'd0,    {8'hFF, 8'h00, 8'h80}, 1'b1, 80'h000000000000_01_80FF00}
  };

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        frame_len_we_i = 1'b0;
  logic [lsbp_pkg::CountW-1:0] frame_len_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  lsbp_pkg::in_beat_t          in_data_i      = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  lsbp_pkg::out_beat_t         out_data_o;

  // Predictor state: register copy, carried partial byte, LEDs in the frame.
  logic [lsbp_pkg::CountW-1:0] led_count_cfg = 13'd1;
  logic [6:0]                  carry_bits    = '0;
  logic [2:0]                  carry_cnt     = '0;
  logic [lsbp_pkg::CountW-1:0] leds_in_frame = '0;

  lsbp_pkg::out_beat_t led_bytes[$];
  lsbp_pkg::out_beat_t stream_q[$];

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned leds_sent     = 0;
  int unsigned bytes_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned count_writes  = 0;

  led_start_bit_stream_packer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_len_we_i (frame_len_we_i),
    .frame_len_i    (frame_len_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // LED count actually used: zero counts as one, large values are clamped.
  function automatic int unsigned effective_count(
      input logic [lsbp_pkg::CountW-1:0] count);
    if (count == '0) begin
      return 1;
    end
    if (count > lsbp_pkg::MaxLeds) begin
      return lsbp_pkg::MaxLeds;
    end
    return 32'(count);
  endfunction

  // Predict the bytes that one LED produces and advance the frame state.
  // The bit string is the carried bits, the header zeros at a frame start,
  // then the start bit and the blue, red, green bytes.
  function automatic void pack_led(input lsbp_pkg::in_beat_t led);
    logic [127:0]        bit_acc;
    int unsigned         eff;
    int unsigned         total;
    int unsigned         header;
    int unsigned         nbits;
    int unsigned         rem;
    logic                frame_end;
    lsbp_pkg::out_beat_t beat;
    led_bytes.delete();
    eff     = effective_count(led_count_cfg);
    bit_acc = 128'(carry_bits) & ((128'd1 << carry_cnt) - 128'd1);
    nbits   = carry_cnt;
    if (leds_in_frame == '0) begin
      total   = eff * lsbp_pkg::LedBits + HeaderBits;
      header  = HeaderBits + ((8 - total % 8) % 8);
      bit_acc = bit_acc << header;
      nbits   = nbits + header;
    end
    bit_acc = (bit_acc << lsbp_pkg::LedBits) |
              128'({1'b1, led.blue, led.red, led.green});
    nbits   = nbits + lsbp_pkg::LedBits;
    rem     = nbits % 8;
    beat    = '0;
    for (int i = 0; i < nbits / 8; i++) begin
      beat.stream_byte = 8'(bit_acc >> (nbits - 8 * (i + 1)));
      led_bytes.push_back(beat);
    end
    bit_acc       = bit_acc & ((128'd1 << rem) - 128'd1);
    leds_in_frame = leds_in_frame + lsbp_pkg::CountW'(1);
    frame_end     = (leds_in_frame >= eff);
    // A frame always ends on a byte boundary; leftover bits are zero padded.
    if (frame_end) begin
      if (rem > 0) begin
        beat.stream_byte = 8'(bit_acc << (8 - rem));
        led_bytes.push_back(beat);
      end
      rem           = 0;
      bit_acc       = '0;
      leds_in_frame = '0;
    end
    beat            = led_bytes.pop_back();
    beat.item_done  = 1'b1;
    beat.frame_done = frame_end;
    led_bytes.push_back(beat);
    carry_bits = 7'(bit_acc);
    carry_cnt  = 3'(rem);
  endfunction

  // Hold off new LEDs until every expected byte is out and the block settles.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (stream_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_led_count(input logic [lsbp_pkg::CountW-1:0] count);
    wait_idle();
    frame_len_we_i <= 1'b1;
    frame_len_i    <= count;
    @(posedge clk_i);
    frame_len_we_i <= 1'b0;
    led_count_cfg = count;
    count_writes++;
  endtask

  // Offer one LED color, optionally after a random gap, and queue its bytes
  // once the beat is taken. Typed rows replace the predicted bytes.
  task automatic send_led(input lsbp_pkg::in_beat_t led, input logic typed,
                          input logic [79:0] typed_stream);
    lsbp_pkg::out_beat_t beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= led;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pack_led(led);
    if (typed) begin
      led_bytes.delete();
      for (int i = 0; i < 10; i++) begin
        beat.stream_byte = typed_stream[79 - 8 * i -: 8];
        beat.item_done   = (i == 9);
        beat.frame_done  = (i == 9);
        led_bytes.push_back(beat);
      end
    end
    foreach (led_bytes[i]) begin
      stream_q.push_back(led_bytes[i]);
    end
    leds_sent++;
  endtask

  // Receiver: random stalls, byte checks and the count of quiet cycles.
  always @(posedge clk_i) begin : stream_monitor
    lsbp_pkg::out_beat_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (stream_q.size() == 0) begin
          $error("stream byte %02h arrived with nothing expected", out_data_o.stream_byte);
          mismatches++;
        end else begin
          want = stream_q.pop_front();
          if (out_data_o.stream_byte !== want.stream_byte) begin
            $error("stream_byte: expected %02h, got %02h",
                   want.stream_byte, out_data_o.stream_byte);
            mismatches++;
          end
          if (out_data_o.item_done !== want.item_done) begin
            $error("item_done: expected %0b, got %0b", want.item_done, out_data_o.item_done);
            mismatches++;
          end
          if (out_data_o.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b",
                   want.frame_done, out_data_o.frame_done);
            mismatches++;
          end
          bytes_checked++;
          if (want.frame_done) begin
            frames_closed++;
          end
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long.
  initial begin
    wait (rst_ni);
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
    end
    $display("Timeout: no beat for %0d cycles, %0d bytes still expected",
             StallLimit, stream_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [lsbp_pkg::CountW-1:0] count;
    int unsigned                 eff;
    int unsigned                 burst;
    int unsigned                 phase_goal;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table with a slow receiver.
    tx_idle_pct = 8;
    rx_idle_pct = 62;
    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowWrite) begin
        write_led_count(DirectedRows[i].count);
      end else begin
        send_led(DirectedRows[i].led, DirectedRows[i].typed, DirectedRows[i].stream);
      end
    end

    // Random bursts: slow receiver, then slow sender, then no idling.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_goal = leds_sent + LedsPerPhase;
      while (leds_sent < phase_goal) begin
        // Mostly short frames; now and then zero, the limit or beyond it.
        case ($urandom_range(19))
          0:       count = '0;
          1:       count = lsbp_pkg::CountW'(lsbp_pkg::MaxLeds);
          2:       count = 13'($urandom_range(8190, lsbp_pkg::MaxLeds + 1));
          3:       count = 13'h1FFF;
          4, 5, 6: count = 13'($urandom_range(40, 9));
          default: count = 13'($urandom_range(8, 1));
        endcase
        write_led_count(count);
        eff = effective_count(count);
        // Usually finish the open frame and maybe one more; otherwise stop
        // at a random point so the next count lands in mid-frame.
        if (eff <= 16 && $urandom_range(3) != 0) begin
          burst = ((leds_in_frame < eff) ? eff - leds_in_frame : 1) +
                  eff * $urandom_range(1, 0);
        end else begin
          burst = $urandom_range(10, 1);
        end
        repeat (burst) send_led(lsbp_pkg::in_beat_t'(24'($urandom)), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Packed %0d LED colors under %0d count settings with three idle patterns.",
             leds_sent, count_writes);
    $display("Checked %0d stream bytes across %0d closed frames.",
             bytes_checked, frames_closed);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== led_start_bit_stream_packer_top.f =====
src/lsbp_pkg.sv
src/lsbp_front.sv
src/lsbp_fifo.sv
src/lsbp_back.sv
src/led_start_bit_stream_packer_top.sv
tb/led_start_bit_stream_packer_top_tb.sv
